@@ rtl/laplacian_edge_filter_rgb_defines.svh @@
// assertion helpers for the edge filter checker
`ifndef LAPLACIAN_EDGE_FILTER_RGB_DEFINES_SVH
`define LAPLACIAN_EDGE_FILTER_RGB_DEFINES_SVH

// same-cycle implication
`define LEF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LEF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lef_pkg.sv @@
package lef_pkg;

  localparam int unsigned MaxWidthDef = 2048;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned NumChan     = 3;
  localparam int unsigned PixW        = ChanW * NumChan;
  localparam int unsigned LineW       = 2 * PixW;
  localparam int unsigned RowW        = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned FrameWidthW = 12;
  localparam int unsigned ResetWidth  = 640;
  localparam int unsigned ResetHeight = 480;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EDGE_MODE    = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_e;

  // 4*c - l - r - u - d for one channel, truncated or clamped magnitude
  function automatic logic [ChanW-1:0] lap_chan(
    input logic             mode,
    input logic [ChanW-1:0] c,
    input logic [ChanW-1:0] l,
    input logic [ChanW-1:0] r,
    input logic [ChanW-1:0] u,
    input logic [ChanW-1:0] d
  );
    logic signed [ChanW+2:0] s;
    logic        [ChanW+2:0] a;
    s = $signed({1'b0, c, 2'b00}) - $signed({3'b000, l}) - $signed({3'b000, r})
        - $signed({3'b000, u}) - $signed({3'b000, d});
    a = s[ChanW+2] ? (ChanW+3)'(-s) : (ChanW+3)'(s);
    if (mode) begin
      return (a > (ChanW+3)'(ChanMax)) ? ChanMax : a[ChanW-1:0];
    end
    return s[ChanW-1:0];
  endfunction

  function automatic logic [PixW-1:0] lap_pixel(
    input logic            mode,
    input logic [PixW-1:0] c,
    input logic [PixW-1:0] l,
    input logic [PixW-1:0] r,
    input logic [PixW-1:0] u,
    input logic [PixW-1:0] d
  );
    logic [PixW-1:0] res;
    for (int i = 0; i < NumChan; i++) begin
      res[i*ChanW +: ChanW] = lap_chan(mode, c[i*ChanW +: ChanW], l[i*ChanW +: ChanW],
                                       r[i*ChanW +: ChanW], u[i*ChanW +: ChanW],
                                       d[i*ChanW +: ChanW]);
    end
    return res;
  endfunction

endpackage

@@ rtl/laplacian_edge_filter_rgb.sv @@
// 4-neighbour Laplacian edge filter for RGB pixels in raster order. One item per clock is
// taken on the input stream, pixels and drain items alike, unless the output is stalled;
// the rate is set by a single line store memory (two read ports, one write port) that is
// read when an item is taken and written back as it leaves stage 1. A pixel of row r > 0
// yields the output pixel of row r-1 at the same column, so output runs one row behind
// input; row 0 yields nothing. Once all rows are in, one drain item per column (tuser = 1)
// flushes the last row and the final one carries tlast. Border pixels pass unchanged.
// Results pass through stage 1 and the output register. edge_mode 0 keeps the low 8 bits
// of the sum, 1 gives its magnitude clamped to 255. Configure only while the block is idle.
module laplacian_edge_filter_rgb #(
  parameter int unsigned MAX_WIDTH = lef_pkg::MaxWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [lef_pkg::PixW-1:0]      s_axis_tdata_i,   // red_in, green_in, blue_in
  input  logic                          s_axis_tuser_i,   // func
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [lef_pkg::PixW-1:0]      m_axis_tdata_o,   // red_out, green_out, blue_out
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lef_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lef_pkg::CfgDataW-1:0]  cfg_data_i
);
  import lef_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam logic [ColW-1:0] ColMax = ColW'(MAX_WIDTH - 1);
  localparam logic [ColW-1:0] RstLastCol =
    ColW'((ResetWidth > MAX_WIDTH) ? MAX_WIDTH - 1 : ResetWidth - 1);

  // configuration
  logic                   mode_q, mode_d;
  logic [ColW-1:0]        last_col_q, last_col_d;
  logic [RowW-1:0]        height_q, height_d;
  logic [FrameWidthW-1:0] cfg_fw;

  assign cfg_ready_o = 1'b1;
  assign cfg_fw      = cfg_data_i[FrameWidthW-1:0];

  always_comb begin
    mode_d     = mode_q;
    last_col_d = last_col_q;
    height_d   = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_EDGE_MODE:   mode_d = cfg_data_i[0];
        REG_FRAME_WIDTH: begin
          if (cfg_fw == '0) begin
            last_col_d = '0;
          end else if (32'(cfg_fw) > MAX_WIDTH) begin
            last_col_d = ColMax;
          end else begin
            last_col_d = ColW'(32'(cfg_fw) - 32'd1);
          end
        end
        REG_FRAME_HEIGHT: height_d = (cfg_data_i == '0) ? RowW'(1) : cfg_data_i[RowW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      last_col_q <= RstLastCol;
      height_q   <= RowW'(ResetHeight);
    end else begin
      mode_q     <= mode_d;
      last_col_q <= last_col_d;
      height_q   <= height_d;
    end
  end

  // input side: position tracking
  logic [ColW-1:0] col_q, col_d, drain_q, drain_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_c, drain_c, cur_c;
  logic            done, is_drain, take, at_last, accept, go;

  // stage 1: memory read data is valid here
  logic                   s1_v_q, s1_v_d;
  logic                   s1_drain_q, s1_emit_q, s1_inner_q, s1_last_q;
  logic [ColW-1:0]        s1_col_q;
  logic [PixW-1:0]        s1_px_q;
  logic                   s1_fire;

  // output register
  logic                   out_v_q, out_v_d, out_load;
  logic [PixW-1:0]        out_data_q;
  logic                   out_last_q;

  logic [PixW-1:0]        win_q;
  logic [LineW-1:0]       rd_a, rd_b;
  logic [PixW-1:0]        prev_c, older_c, right_c, res;
  logic                   wr_en;

  assign done     = row_q >= height_q;
  assign col_c    = (col_q > last_col_q) ? last_col_q : col_q;
  assign drain_c  = (drain_q > last_col_q) ? last_col_q : drain_q;
  assign is_drain = (s_axis_tuser_i == FUNC_DRAIN);
  assign take     = is_drain ? done : !done;
  assign cur_c    = is_drain ? drain_c : col_c;
  assign at_last  = (cur_c == last_col_q);

  assign s1_fire         = s1_v_q && (!s1_emit_q || !out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_v_q || s1_fire;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign go              = accept && take;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    if (go) begin
      if (at_last) begin
        col_d   = '0;
        drain_d = '0;
        row_d   = is_drain ? '0 : row_q + RowW'(1);
      end else if (is_drain) begin
        drain_d = cur_c + ColW'(1);
      end else begin
        col_d = cur_c + ColW'(1);
      end
    end
  end

  assign s1_v_d = go ? 1'b1 : (s1_fire ? 1'b0 : s1_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      win_q   <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
      if (wr_en) begin
        win_q <= prev_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      s1_drain_q <= is_drain;
      s1_emit_q  <= is_drain || (row_q != '0);
      s1_inner_q <= !is_drain && (row_q >= RowW'(2)) && (cur_c != '0) && !at_last;
      s1_last_q  <= is_drain && at_last;
      s1_col_q   <= cur_c;
      s1_px_q    <= s_axis_tdata_i;
    end
  end

  lef_line_store #(
    .Depth(MAX_WIDTH)
  ) u_line_store (
    .clk_i      (clk_i),
    .rd_en_i    (go),
    .rd_a_addr_i(cur_c),
    .rd_b_addr_i(cur_c + ColW'(1)),
    .rd_a_data_o(rd_a),
    .rd_b_data_o(rd_b),
    .wr_en_i    (wr_en),
    .wr_addr_i  (s1_col_q),
    .wr_data_i  ({prev_c, s1_px_q})
  );

  assign prev_c  = rd_a[PixW-1:0];
  assign older_c = rd_a[LineW-1:PixW];
  assign right_c = rd_b[PixW-1:0];
  assign wr_en   = s1_fire && !s1_drain_q;
  assign res     = s1_inner_q ? lap_pixel(mode_q, prev_c, win_q, right_c, older_c, s1_px_q)
                              : prev_c;

  assign out_load = s1_fire && s1_emit_q;
  assign out_v_d  = out_load || (out_v_q && !m_axis_tready_i);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ rtl/lef_line_store.sv @@
module lef_line_store #(
  parameter int unsigned Depth = lef_pkg::MaxWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(Depth)-1:0]   rd_a_addr_i,
  input  logic [$clog2(Depth)-1:0]   rd_b_addr_i,
  output logic [lef_pkg::LineW-1:0]  rd_a_data_o,
  output logic [lef_pkg::LineW-1:0]  rd_b_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(Depth)-1:0]   wr_addr_i,
  input  logic [lef_pkg::LineW-1:0]  wr_data_i
);
  import lef_pkg::*;

  // each entry: {older row pixel, previous row pixel}
  logic [LineW-1:0] mem [Depth];
  logic [LineW-1:0] rd_a_q;
  logic [LineW-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // write-first forwarding for a read of the entry written in the same cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= (wr_en_i && (wr_addr_i == rd_a_addr_i)) ? wr_data_i : mem[rd_a_addr_i];
      rd_b_q <= (wr_en_i && (wr_addr_i == rd_b_addr_i)) ? wr_data_i : mem[rd_b_addr_i];
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

@@ rtl/lef_checker.sv @@
`include "laplacian_edge_filter_rgb_defines.svh"

module lef_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid_i,
  input logic                     s_axis_tready_o,
  input logic                     m_axis_tvalid_o,
  input logic                     m_axis_tready_i,
  input logic [lef_pkg::PixW-1:0] m_axis_tdata_o
);
  import lef_pkg::*;

  logic [PixW-1:0] tdata_mon;
  assign tdata_mon = m_axis_tdata_o;

  `LEF_ASSERT_NXT(a_out_valid_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "output item dropped while stalled")

  `LEF_ASSERT_NXT(a_out_data_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, $stable(tdata_mon), "output item changed while stalled")

  `LEF_ASSERT_IMP(a_stall_from_output, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o && !m_axis_tready_i, "input stalled without output backpressure")

  `LEF_ASSERT_IMP(a_out_follows_in, clk_i, rst_ni, $rose(m_axis_tvalid_o), $past(s_axis_tvalid_i && s_axis_tready_o, 2), "output item without an accepted input item")

endmodule

bind laplacian_edge_filter_rgb lef_checker u_lef_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
